### rtl/core/oli_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the ordered list block.
package oli_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_INSERT  = 3'd1,
        OP_PREPEND = 3'd2,
        OP_POP     = 3'd3,
        OP_DELETE  = 3'd4,
        OP_FIND    = 3'd5,
        OP_REMOVE  = 3'd6,
        OP_READ    = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_RANGE    = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_UP,
        S_PUT,
        S_DOWN,
        S_SEARCH,
        S_FETCH,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_DEC,
        PTR_INC,
        PTR_LAST,
        PTR_AFTER,
        PTR_IDX
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_POS,
        WR_UP,
        WR_DOWN
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        IDX_ZERO,
        IDX_PTR,
        IDX_FOUND
    } idx_sel_t;

    typedef struct packed {
        logic     load_req;
        ptr_op_t  ptr_op;
        logic     wr_en;
        wr_sel_t  wr_sel;
        cnt_op_t  cnt_op;
        logic     found_load;
        logic     res_load;
        status_t  res_status;
        logic     res_item_rd;
        idx_sel_t res_index_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic pos_range;
        logic full;
        logic pos_is_end;
        logic idx_oob;
        logic empty;
        logic after_is_end;
        logic ptr_at_pos;
        logic ptr_last;
        logic ptr_zero;
        logic match;
        logic out_free;
    } flags_t;

endpackage

### rtl/core/oli_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the ordered list block.
interface oli_req_if;
    logic                         valid;
    logic                         ready;
    logic [oli_pkg::MODE_W-1:0]   mode;
    logic [oli_pkg::INDEX_W-1:0]  index;
    logic [oli_pkg::ITEM_W-1:0]   item;

    modport source (output valid, output mode, output index, output item, input ready);
    modport sink   (input valid, input mode, input index, input item, output ready);
endinterface

interface oli_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [oli_pkg::ITEM_W-1:0]    item_out;
    logic [oli_pkg::INDEX_W-1:0]   index_out;
    logic [oli_pkg::STATUS_W-1:0]  status;
    logic [oli_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output item_out, output index_out, output status,
                    output count, input ready);
    modport sink   (input valid, input item_out, input index_out, input status,
                    input count, output ready);
endinterface

### rtl/core/oli_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module oli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/oli_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer of the ordered list block.
module oli_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  oli_pkg::flags_t flg,
    output oli_pkg::cmd_t   cmd
);
    import oli_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (flg.op)
                    OP_PUSH, OP_INSERT, OP_PREPEND:
                    begin
                        if (flg.pos_range || flg.full)
                        begin
                            state_next = S_DONE;
                        end
                        else if (flg.pos_is_end)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_UP;
                        end
                    end
                    OP_POP:
                    begin
                        state_next = flg.empty ? S_DONE : S_FETCH;
                    end
                    OP_READ:
                    begin
                        state_next = flg.idx_oob ? S_DONE : S_FETCH;
                    end
                    OP_DELETE:
                    begin
                        if (flg.idx_oob || flg.after_is_end)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DOWN;
                        end
                    end
                    default:
                    begin
                        state_next = flg.empty ? S_DONE : S_SEARCH;
                    end
                endcase
            end
            S_UP:
            begin
                if (flg.ptr_at_pos)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DOWN:
            begin
                if (flg.ptr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                if (flg.match)
                begin
                    if (flg.op == OP_FIND || flg.ptr_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DOWN;
                    end
                end
                else if (flg.ptr_zero)
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (flg.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        cmd.ptr_op        = PTR_HOLD;
        cmd.wr_sel        = WR_POS;
        cmd.cnt_op        = CNT_HOLD;
        cmd.res_status    = STS_OK;
        cmd.res_index_sel = IDX_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            S_DECIDE:
            begin
                case (flg.op)
                    OP_PUSH, OP_INSERT, OP_PREPEND:
                    begin
                        if (flg.pos_range)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_RANGE;
                        end
                        else if (flg.full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_FULL;
                        end
                        else if (!flg.pos_is_end)
                        begin
                            cmd.ptr_op = PTR_LAST;
                        end
                    end
                    OP_POP:
                    begin
                        if (flg.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_EMPTY;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_LAST;
                        end
                    end
                    OP_READ:
                    begin
                        if (flg.idx_oob)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_RANGE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_IDX;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (flg.idx_oob)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_RANGE;
                        end
                        else if (flg.after_is_end)
                        begin
                            cmd.cnt_op   = CNT_DEC;
                            cmd.res_load = 1'b1;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_AFTER;
                        end
                    end
                    default:
                    begin
                        if (flg.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_NOTFOUND;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_LAST;
                        end
                    end
                endcase
            end
            S_UP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_UP;
                if (!flg.ptr_at_pos)
                begin
                    cmd.ptr_op = PTR_DEC;
                end
            end
            S_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_POS;
                cmd.cnt_op   = CNT_INC;
                cmd.res_load = 1'b1;
            end
            S_DOWN:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DOWN;
                if (flg.ptr_last)
                begin
                    cmd.cnt_op        = CNT_DEC;
                    cmd.res_load      = 1'b1;
                    cmd.res_index_sel = (flg.op == OP_REMOVE) ? IDX_FOUND : IDX_ZERO;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_SEARCH:
            begin
                if (flg.match)
                begin
                    cmd.found_load = 1'b1;
                    if (flg.op == OP_FIND)
                    begin
                        cmd.res_load      = 1'b1;
                        cmd.res_index_sel = IDX_PTR;
                    end
                    else if (flg.ptr_last)
                    begin
                        cmd.cnt_op        = CNT_DEC;
                        cmd.res_load      = 1'b1;
                        cmd.res_index_sel = IDX_PTR;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_INC;
                    end
                end
                else if (flg.ptr_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_NOTFOUND;
                end
                else
                begin
                    cmd.ptr_op = PTR_DEC;
                end
            end
            S_FETCH:
            begin
                cmd.res_load    = 1'b1;
                cmd.res_item_rd = 1'b1;
                if (flg.op == OP_POP)
                begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_DONE:
            begin
                cmd.out_load = flg.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/oli_dp.sv
`timescale 1ns / 1ps
// Datapath of the ordered list block: entry store, count, walk pointer, result stages.
module oli_dp #(
    parameter int DEPTH      = oli_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = oli_pkg::ITEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [oli_pkg::MODE_W-1:0]    req_mode,
    input  logic [oli_pkg::INDEX_W-1:0]   req_index,
    input  logic [oli_pkg::ITEM_W-1:0]    req_item,
    input  oli_pkg::cmd_t                 cmd,
    output oli_pkg::flags_t               flg,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic [oli_pkg::ITEM_W-1:0]    item_out,
    output logic [oli_pkg::INDEX_W-1:0]   index_out,
    output logic [oli_pkg::STATUS_W-1:0]  status,
    output logic [oli_pkg::COUNT_W-1:0]   count
);
    import oli_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

    op_t                   mode_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         ptr_reg;
    logic [CW-1:0]         ptr_next;
    logic [CW-1:0]         found_reg;

    logic [CMPW-1:0]       count_x;
    logic [CMPW-1:0]       idx_x;
    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       ptr_x;

    logic [AW-1:0]         wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic [ITEM_WIDTH-1:0] rd_data;

    logic [ITEM_W-1:0]     res_item_reg;
    logic [INDEX_W-1:0]    res_index_reg;
    status_t               res_status_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic [INDEX_W-1:0]    res_index_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ITEM_W-1:0]     out_item_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    status_t               out_status_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    assign count_x = CMPW'(count_reg);
    assign idx_x   = CMPW'(idx_reg);
    assign ptr_x   = CMPW'(ptr_reg);

    always_comb
    begin
        case (mode_reg)
            OP_PUSH:    pos_x = count_x;
            OP_PREPEND: pos_x = '0;
            default:    pos_x = idx_x;
        endcase
    end

    always_comb
    begin
        flg.op           = mode_reg;
        flg.pos_range    = pos_x > count_x;
        flg.full         = count_reg == CW'(DEPTH);
        flg.pos_is_end   = pos_x == count_x;
        flg.idx_oob      = idx_x >= count_x;
        flg.empty        = count_reg == '0;
        flg.after_is_end = (idx_x + CMPW'(1)) == count_x;
        flg.ptr_at_pos   = ptr_x == pos_x;
        flg.ptr_last     = (ptr_reg + CW'(1)) == count_reg;
        flg.ptr_zero     = ptr_reg == '0;
        flg.match        = rd_data == item_reg;
        flg.out_free     = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    // The read port always follows the pointer, so read data matches ptr_reg.
    always_comb
    begin
        case (cmd.ptr_op)
            PTR_DEC:   ptr_next = ptr_reg - CW'(1);
            PTR_INC:   ptr_next = ptr_reg + CW'(1);
            PTR_LAST:  ptr_next = count_reg - CW'(1);
            PTR_AFTER: ptr_next = CW'(idx_x + CMPW'(1));
            PTR_IDX:   ptr_next = CW'(idx_x);
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_UP:   wr_addr = AW'(ptr_reg + CW'(1));
            WR_DOWN: wr_addr = AW'(ptr_reg - CW'(1));
            default: wr_addr = pos_x[AW-1:0];
        endcase
        wr_data = (cmd.wr_sel == WR_POS) ? item_reg : rd_data;
    end

    oli_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (1'b1),
        .rd_addr (ptr_next[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (cmd.res_index_sel)
            IDX_PTR:   res_index_next = INDEX_W'(ptr_reg);
            IDX_FOUND: res_index_next = INDEX_W'(found_reg);
            default:   res_index_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= op_t'(req_mode);
            idx_reg  <= req_index;
            item_reg <= ITEM_WIDTH'(req_item);
        end
        if (cmd.found_load)
        begin
            found_reg <= ptr_reg;
        end
        if (cmd.res_load)
        begin
            res_item_reg   <= cmd.res_item_rd ? ITEM_W'(rd_data) : '0;
            res_index_reg  <= res_index_next;
            res_status_reg <= cmd.res_status;
            res_count_reg  <= COUNT_W'(count_next);
        end
        if (cmd.out_load)
        begin
            out_item_reg   <= res_item_reg;
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign item_out  = out_item_reg;
    assign index_out = out_index_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

endmodule

### rtl/core/ordered_list_insert_delete_find_top.sv
`timescale 1ns / 1ps
// Ordered list of item handles: push, pop and read need no walk and a request that is
// refused is answered at once, while insert, prepend, delete, find and remove walk the
// stored entries as needed, one per cycle, through the entry RAM's single read and single
// write port; a response may also wait for the sink. The list itself needs no clearing
// pass: only positions below the count are ever read. A finished beat sits in an output
// register, so the next request is taken while the previous response still waits for
// the sink.
module ordered_list_insert_delete_find_top #(
    parameter int DEPTH      = oli_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = oli_pkg::ITEM_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    oli_req_if.sink    req,
    oli_rsp_if.source  rsp
);
    import oli_pkg::*;

    cmd_t   cmd;
    flags_t flg;

    // Sequencer: decodes each request and steps the walk over the entries
    oli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .flg       (flg),
        .cmd       (cmd)
    );

    // Datapath: entry RAM, count, walk pointer and the result/output registers
    oli_dp #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_mode  (req.mode),
        .req_index (req.index),
        .req_item  (req.item),
        .cmd       (cmd),
        .flg       (flg),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .item_out  (rsp.item_out),
        .index_out (rsp.index_out),
        .status    (rsp.status),
        .count     (rsp.count)
    );

    // Hold off new requests for the whole of a request's work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while the previous one is still in work");

    // Never overwrite a response beat that the sink has not taken
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> flg.out_free)
        else $error("output register loaded over a pending beat");

    // Grow the list only when there is room
    a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == CNT_INC) |-> !flg.full)
        else $error("count advanced on a full list");

    // Store the new item only together with the count increment
    a_put_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == WR_POS) |-> (cmd.cnt_op == CNT_INC && cmd.res_load))
        else $error("item stored without a count increment");

endmodule
